// ----- sv/ale_pkg.sv -----
// ----------------------------------------------------------------------------
// ale_pkg: shared types and constants for the associated Legendre evaluator
// Holds the request/response words, the sequencer states and the fixed
// datapath widths used by associated_legendre_eval_top.
// ----------------------------------------------------------------------------
package ale_pkg;

  // Datapath widths, sized for degrees up to eight.
  localparam int P_W       = 40;             // P values, signed Q.16
  localparam int B_W       = 20;             // second multiplier operand
  localparam int HALF_W    = P_W / 2;        // split point of the first operand
  localparam int MUL_W     = HALF_W + 1 + B_W;
  localparam int ACC_W     = P_W + B_W;      // full product
  localparam int FRAC      = 14;             // fraction bits of x and the root
  localparam int NUM_W     = ACC_W - FRAC;   // recurrence numerator
  localparam int REM_W     = 29;             // root remainder, holds 2^28
  localparam int ROOT_W    = 30;
  localparam int S_W       = 15;             // root result, at most 2^14
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic signed [15:0]     X_MAX      = 16'sh4000;
  localparam logic signed [15:0]     X_MIN      = 16'shC000;
  localparam logic signed [P_W-1:0]  ONE_Q16    = P_W'(65536);
  localparam logic signed [24:0]     OUT_MAX    = 25'h0FF_FFFF;
  localparam logic signed [24:0]     OUT_MIN    = 25'h100_0000;
  localparam logic [REM_W-1:0]       ROOT_BASE  = REM_W'(29'h1000_0000);

  typedef struct packed {
    logic [3:0]         degree;
    logic [3:0]         order;
    logic signed [15:0] arg;
  } ale_req_t;

  typedef struct packed {
    logic signed [24:0] value;
    logic               saturated;
  } ale_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQ_W,
    ST_ROOT,
    ST_PMM_C,
    ST_PMM_M,
    ST_PMM_W,
    ST_CHK,
    ST_P1_M,
    ST_P1_W,
    ST_R_C,
    ST_R_M,
    ST_R_T,
    ST_R_S,
    ST_DIV,
    ST_R_W,
    ST_DONE
  } state_t;

endpackage

// ----- sv/associated_legendre_eval_top.sv -----
// ----------------------------------------------------------------------------
// associated_legendre_eval_top: P_l^m(x) evaluator with one shared multiplier
// Throughput: one word at a time; the next request is taken in the cycle
// after the response word leaves. The per-degree cost is set by the
// bit-serial divide and the two-pass 21x20 multiplier.
// Reset returns the sequencer to idle; no other state survives between words.
// ----------------------------------------------------------------------------
module associated_legendre_eval_top
  import ale_pkg::*;
#(
  parameter int MAX_DEGREE = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  ale_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output ale_rsp_t rsp
);

  localparam logic [3:0] MAX_DEG_L = 4'(MAX_DEGREE);

  // Sequencer
  state_t state, state_next;
  state_t mul_ret;
  logic   mul_phase;

  // Item registers
  logic [3:0]         l_q;
  logic [3:0]         m_q;
  logic [3:0]         i_q;
  logic signed [15:0] x_q;

  // Shared multiplier: a 40-bit operand split in two halves, two passes
  logic signed [P_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [HALF_W:0]  mul_op;
  logic signed [MUL_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc;

  // Square root
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  sbit;
  logic [ROOT_W-1:0] trial;

  // Recurrence values
  logic signed [P_W-1:0]   pmm;
  logic signed [P_W-1:0]   pm1;
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] diff;
  logic signed [P_W-1:0]   prod_q;

  // Bit-serial divider
  logic [NUM_W-1:0]     div_q;
  logic [3:0]           div_r;
  logic [3:0]           div_d;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_neg;
  logic [4:0]           div_shift;
  logic [NUM_W-1:0]     quot;

  // Response register
  logic signed [24:0] res_value;
  logic               res_sat;

  // Clamped request fields
  logic [3:0]         deg_cl;
  logic signed [15:0] x_cl;
  logic               accept;

  // Small coefficients
  logic [4:0] coef_odd;   // 2i-1
  logic [4:0] coef_m;     // 2m+1
  logic [4:0] coef_sub;   // i+m-1

  function automatic ale_rsp_t clip(input logic signed [P_W-1:0] v);
    ale_rsp_t r;
    r.saturated = 1'b1;
    if (v > P_W'(OUT_MAX)) begin
      r.value = OUT_MAX;
    end else if (v < P_W'(OUT_MIN)) begin
      r.value = OUT_MIN;
    end else begin
      r.value     = v[24:0];
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  assign accept = req_valid && !req_stall;
  assign deg_cl = (req.degree > MAX_DEG_L) ? MAX_DEG_L : req.degree;
  assign x_cl   = (req.arg > X_MAX) ? X_MAX : ((req.arg < X_MIN) ? X_MIN : req.arg);

  assign coef_odd = {i_q, 1'b0} - 5'd1;
  assign coef_m   = {m_q, 1'b1};
  assign coef_sub = {1'b0, i_q} + {1'b0, m_q} - 5'd1;

  // Low pass takes the unsigned low half, high pass the signed high half.
  assign mul_op   = mul_phase ? {mul_a[P_W-1], mul_a[P_W-1:HALF_W]}
                              : {1'b0, mul_a[HALF_W-1:0]};
  assign prod     = mul_op * mul_b;
  assign prod_ext = {{(ACC_W-MUL_W){prod[MUL_W-1]}}, prod};

  // Floor of the product by 2^14: arithmetic drop of the fraction bits.
  assign prod_q = acc[FRAC +: P_W];

  assign trial     = root + ROOT_W'(sbit);
  assign diff      = num - acc[NUM_W-1:0];
  assign div_shift = {div_r, div_q[NUM_W-1]};
  assign quot      = div_neg ? (NUM_W'(0) - div_q) : div_q;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.order > deg_cl) begin
            state_next = ST_DONE;      // order above degree: zero result
          end else if (req.order == 4'd0) begin
            state_next = ST_CHK;       // P_0^0 is exactly one
          end else begin
            state_next = ST_MUL;       // x*x for the root
          end
        end
      end
      ST_MUL:   if (mul_phase) state_next = mul_ret;
      ST_SQ_W:  state_next = ST_ROOT;
      ST_ROOT:  if (sbit == REM_W'(1)) state_next = ST_PMM_C;
      ST_PMM_C: state_next = ST_MUL;
      ST_PMM_M: state_next = ST_MUL;
      ST_PMM_W: state_next = (i_q == m_q) ? ST_CHK : ST_PMM_C;
      ST_CHK:   state_next = (l_q == m_q) ? ST_DONE : ST_MUL;
      ST_P1_M:  state_next = ST_MUL;
      ST_P1_W: begin
        if (({1'b0, m_q} + 5'd2) > {1'b0, l_q}) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_R_C;
        end
      end
      ST_R_C:   state_next = ST_MUL;
      ST_R_M:   state_next = ST_MUL;
      ST_R_T:   state_next = ST_MUL;
      ST_R_S:   state_next = ST_DIV;
      ST_DIV:   if (div_cnt == '0) state_next = ST_R_W;
      ST_R_W:   state_next = (i_q == l_q) ? ST_DONE : ST_R_C;
      ST_DONE:  if (!rsp_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake outputs
  // --------------------------------------------------------------------------
  always_comb begin
    req_stall       = (state != ST_IDLE);
    rsp_valid       = (state == ST_DONE);
    rsp.value       = res_value;
    rsp.saturated   = res_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_phase <= 1'b0;
    end else begin
      state     <= state_next;
      mul_phase <= (state == ST_MUL) ? !mul_phase : 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // Latch the clamped request and set up x*x.
        if (accept) begin
          l_q       <= deg_cl;
          m_q       <= req.order;
          x_q       <= x_cl;
          i_q       <= 4'd1;
          pmm       <= ONE_Q16;
          mul_a     <= {{(P_W-16){x_cl[15]}}, x_cl};
          mul_b     <= {{(B_W-16){x_cl[15]}}, x_cl};
          mul_ret   <= ST_SQ_W;
          res_value <= '0;
          res_sat   <= 1'b0;
        end
      end
      ST_MUL: begin
        // Low half first, then add the high half shifted up.
        if (!mul_phase) begin
          acc <= prod_ext;
        end else begin
          acc <= acc + {prod_ext[ACC_W-1-HALF_W:0], {HALF_W{1'b0}}};
        end
      end
      ST_SQ_W: begin
        rem  <= ROOT_BASE - acc[REM_W-1:0];
        root <= '0;
        sbit <= ROOT_BASE;
      end
      ST_ROOT: begin
        // One digit of the floor square root per cycle.
        if (ROOT_W'(rem) >= trial) begin
          rem  <= rem - trial[REM_W-1:0];
          root <= (root >> 1) + ROOT_W'(sbit);
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
      end
      ST_PMM_C: begin
        // -(2i-1) * sqrt(1-x^2)
        mul_a   <= P_W'(root[S_W-1:0]);
        mul_b   <= B_W'(0) - B_W'(coef_odd);
        mul_ret <= ST_PMM_M;
      end
      ST_PMM_M: begin
        mul_a   <= pmm;
        mul_b   <= acc[B_W-1:0];
        mul_ret <= ST_PMM_W;
      end
      ST_PMM_W: begin
        pmm <= prod_q;
        i_q <= i_q + 4'd1;
      end
      ST_CHK: begin
        {res_value, res_sat} <= clip(pmm);
        mul_a   <= {{(P_W-16){x_q[15]}}, x_q};
        mul_b   <= B_W'(coef_m);
        mul_ret <= ST_P1_M;
      end
      ST_P1_M: begin
        mul_a   <= pmm;
        mul_b   <= acc[B_W-1:0];
        mul_ret <= ST_P1_W;
      end
      ST_P1_W: begin
        pm1                  <= prod_q;
        {res_value, res_sat} <= clip(prod_q);
        i_q                  <= m_q + 4'd2;
      end
      ST_R_C: begin
        mul_a   <= {{(P_W-16){x_q[15]}}, x_q};
        mul_b   <= B_W'(coef_odd);
        mul_ret <= ST_R_M;
      end
      ST_R_M: begin
        mul_a   <= pm1;
        mul_b   <= acc[B_W-1:0];
        mul_ret <= ST_R_T;
      end
      ST_R_T: begin
        // Hold the floored first term, then form (i+m-1) * P_{i-2}.
        num     <= acc[ACC_W-1:FRAC];
        mul_a   <= pmm;
        mul_b   <= B_W'(coef_sub);
        mul_ret <= ST_R_S;
      end
      ST_R_S: begin
        // Divide the magnitude, restore the sign after: truncates toward zero.
        div_neg <= diff[NUM_W-1];
        div_q   <= diff[NUM_W-1] ? (NUM_W'(0) - diff) : diff;
        div_r   <= '0;
        div_d   <= i_q - m_q;
        div_cnt <= DIV_CNT_W'(NUM_W - 1);
      end
      ST_DIV: begin
        if (div_shift >= {1'b0, div_d}) begin
          div_r <= 4'(div_shift - {1'b0, div_d});
          div_q <= {div_q[NUM_W-2:0], 1'b1};
        end else begin
          div_r <= div_shift[3:0];
          div_q <= {div_q[NUM_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      ST_R_W: begin
        // Advance the recurrence by one degree.
        pmm                  <= pm1;
        pm1                  <= quot[P_W-1:0];
        {res_value, res_sat} <= clip(quot[P_W-1:0]);
        i_q                  <= i_q + 4'd1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted request word did not start the sequencer");

  a_mul_two_pass: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && !mul_phase) |=> (state == ST_MUL && mul_phase))
    else $error("multiplier left after a single pass");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_d != 4'd0))
    else $error("recurrence divisor is zero");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.saturated) |-> (rsp.value == OUT_MAX || rsp.value == OUT_MIN))
    else $error("saturated response word is not at a range bound");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while a response word waits");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for associated_legendre_eval_top
// Sends request words (degree, order, argument) under random idle on the request
// side and random stall on the response side. A scoreboard computes P_l^m(x) for every accepted
// request and compares each response word with the oldest outstanding one.
// ----------------------------------------------------------------------------
module tb
  import ale_pkg::*;
();

  localparam int MAX_DEG      = 4;
  localparam int IDLE_PCT     = 23;
  localparam int RANDOM_WORDS = 1930;
  // Window of request words sent with both sides held busy-free.
  localparam int CALM_FIRST   = 700;
  localparam int CALM_LAST    = 1000;
  // The slowest word is order 0 at the top degree.
  localparam int DRAIN_CYCLES = 250;

  // --------------------------------------------------------------------------
  // Scoreboard: computes the expected response word for each accepted request
  // and checks the responses in order.
  // --------------------------------------------------------------------------
  class legendre_scoreboard;
    ale_rsp_t expected_words[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    task flag_mismatch(string what);
      $display("[%0t] error: %s", $time, what);
      mismatches++;
    endtask

    // P_l^m(x) in Q.16: closed form for P_m^m, one step up, then the
    // three-term recurrence. Products with x or the root floor; the divide
    // truncates toward zero.
    function ale_rsp_t legendre_value(ale_req_t w);
      longint   l, m, x, root, rad, trial, pmm, pm1, num, res;
      int       i, b;
      ale_rsp_t r;
      l = w.degree;
      m = w.order;
      x = w.arg;
      if (x > X_MAX) x = X_MAX;
      if (x < X_MIN) x = X_MIN;
      if (l > MAX_DEG) l = MAX_DEG;
      res = 0;
      if (m <= l) begin
        pmm = 65536;
        if (m > 0) begin
          // floor of sqrt(1 - x^2) in Q1.14, one bit at a time
          rad  = (64'sd1 <<< 28) - x * x;
          root = 0;
          for (b = 14; b >= 0; b--) begin
            trial = root | (64'sd1 <<< b);
            if (trial * trial <= rad) root = trial;
          end
          for (i = 1; i <= m; i++) pmm = (pmm * (-(2 * i - 1) * root)) >>> 14;
        end
        if (l == m) begin
          res = pmm;
        end else begin
          pm1 = ((2 * m + 1) * pmm * x) >>> 14;
          for (i = m + 2; i <= l; i++) begin
            num = (((2 * i - 1) * pm1 * x) >>> 14) - (i + m - 1) * pmm;
            pmm = pm1;
            pm1 = num / (i - m);
          end
          res = pm1;
        end
      end
      r.saturated = 1'b0;
      if (res > OUT_MAX) begin
        res = OUT_MAX;
        r.saturated = 1'b1;
      end else if (res < OUT_MIN) begin
        res = OUT_MIN;
        r.saturated = 1'b1;
      end
      r.value = res[24:0];
      return r;
    endfunction

    function void note_request(ale_req_t w);
      expected_words.push_back(legendre_value(w));
    endfunction

    task check_response(ale_rsp_t got);
      ale_rsp_t want;
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("response word with none outstanding: value %0d sat %0b",
                                got.value, got.saturated));
      end else begin
        want = expected_words.pop_front();
        if (got.value !== want.value)
          flag_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
        if (got.saturated !== want.saturated)
          flag_mismatch($sformatf("saturated %0b, want %0b", got.saturated,
                                  want.saturated));
      end
    endtask

    function int outstanding();
      return expected_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  ale_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  ale_rsp_t rsp;
  logic     calm      = 1'b0;

  legendre_scoreboard sb = new();

  always #2 clk = ~clk;

  associated_legendre_eval_top #(
    .MAX_DEGREE(MAX_DEG)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // Stall the response side at random; drop stalls during the calm window.
  always @(posedge clk) begin
    rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // Check every response word taken at this edge. Inputs change only by
  // nonblocking assignment, so the values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // Offer one request word: at random, and never in the calm window, idle a random
  // number of cycles first (valid low), then hold valid and payload steady until the word is taken.
  task automatic send_word(input ale_req_t w);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
    sb.note_request(w);
  endtask

  task automatic send_fields(input int l, input int m, input int a);
    ale_req_t w;
    w.degree = 4'(l);
    w.order  = 4'(m);
    w.arg    = 16'(a);
    send_word(w);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: directed corners first, then mostly well-formed random words
  // with some raw noise that exercises every field bit.
  // --------------------------------------------------------------------------
  initial begin
    ale_req_t w;
    int       n;
    int       l;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Order zero at the smallest degree: exactly one.
    send_fields(0, 0, 0);
    // Top degree, argument at both ends and at zero.
    send_fields(MAX_DEG, 0, 16384);
    send_fields(MAX_DEG, 0, -16384);
    send_fields(MAX_DEG, 0, 0);
    // Full order: root is zero at the top end, largest magnitude at and near zero.
    send_fields(MAX_DEG, MAX_DEG, 16384);
    send_fields(MAX_DEG, MAX_DEG, 0);
    send_fields(MAX_DEG, MAX_DEG, -1);
    // Every order between zero and full at the top degree.
    for (n = 1; n < MAX_DEG; n++) send_fields(MAX_DEG, n, 9000 - 4000 * n);
    // Order above degree gives zero.
    send_fields(2, 3, 5000);
    send_fields(0, 15, -7000);
    send_fields(15, 15, 12345);
    // Degree above the bound folds to the bound.
    send_fields(15, 0, 8000);
    send_fields(9, 2, -3000);
    // Arguments beyond -1..1 clamp.
    send_fields(3, 1, 32767);
    send_fields(3, 0, -32768);
    send_fields(2, 2, 16385);
    send_fields(2, 0, -16385);
    // Smallest nonzero arguments.
    send_fields(3, 0, 1);
    send_fields(3, 0, -1);
    send_fields(1, 1, 1);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if ($urandom_range(99) < 80) begin
        l        = $urandom_range(MAX_DEG);
        w.degree = 4'(l);
        w.order  = 4'($urandom_range(l));
        w.arg    = 16'(int'($urandom_range(32768)) - 16384);
      end else begin
        w = ale_req_t'(24'($urandom));
      end
      send_word(w);
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    // Drain what is outstanding, then watch for stray response words.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ale_pkg.sv
sv/associated_legendre_eval_top.sv
bench/tb.sv
